/* design/bcdc_pkg.sv */
// Package for the bounded calendar date counter: field widths, opcode and
// status codes, the date record, and the month-length and leap-year helpers.
// No dependencies.
`default_nettype none

package bcdc_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;

    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [YEAR_W-1:0] FIRST_YEAR_RST = 14'd2019;
    localparam logic [YEAR_W-1:0] LAST_YEAR_RST  = 14'd2021;

    // 25 * 7209 == 1 mod 2^14; y is a multiple of 25 iff y*7209 mod 2^14 <= 16383/25
    localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_NEXT = 2'd1,
        OP_PREV = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LOAD = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    // divisible by 4 and not by 100, or divisible by 400
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        prod  = y * INV25;
        div25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
        return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic               leap);
        logic [DAY_W-1:0] len;
        if (m == MONTH_FEB)
            len = leap ? 5'd29 : 5'd28;
        else if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV})
            len = 5'd30;
        else
            len = 5'd31;
        return len;
    endfunction

endpackage

`default_nettype wire

/* design/bounded_calendar_date_counter.sv */
// Top level of the bounded calendar date counter: beat handshakes, APB
// register file, input and result registers, held date.
// Depends on bcdc_pkg and bcdc_step.
`default_nettype none

// Holds one Gregorian date (day, month, year, reset January 1, 2019) kept
// inside a window of years set by first_year (byte address 0) and last_year
// (byte address 4), reset 2019 and 2021. Each input beat carries an opcode:
// load (checked against month lengths, the leap-year rule and the window),
// next day or previous day. Each input beat gives exactly one result beat
// with the date after the operation and a status: ok, invalid load, or a
// step past January 1 of first_year / December 31 of last_year. Opcode 3
// is a no-op that reports ok. A step that stays within the held year is not
// checked against the window. Throughput is one beat per clock while
// out_stall is low; an accepted beat passes the input register, then the
// date update and result register in the same edge. in_stall only rises
// when the result register is full and stalled and the input register is
// occupied. Write the year registers only while no beat is in flight.
module bounded_calendar_date_counter
    import bcdc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    // input beats
    input  wire logic                in_valid,
    output      logic                in_stall,
    input  wire logic [1:0]          opcode,
    input  wire logic [DAY_W-1:0]    load_day,
    input  wire logic [MONTH_W-1:0]  load_month,
    input  wire logic [YEAR_W-1:0]   load_year,

    // result beats
    output      logic                out_valid,
    input  wire logic                out_stall,
    output      logic [DAY_W-1:0]    cur_day,
    output      logic [MONTH_W-1:0]  cur_month,
    output      logic [YEAR_W-1:0]   cur_year,
    output      logic [1:0]          status,

    // APB register port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output      logic [31:0]         prdata,
    output      logic                pready
);

    // ---------------- register file ----------------
    logic [YEAR_W-1:0] first_year_reg, first_year_next;
    logic [YEAR_W-1:0] last_year_reg, last_year_next;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // paddr[2] selects the register; low bits ignored
    always_comb
    begin
        first_year_next = first_year_reg;
        last_year_next  = last_year_reg;
        if (cfg_wr)
        begin
            if (paddr[2])
                last_year_next = pwdata[YEAR_W-1:0];
            else
                first_year_next = pwdata[YEAR_W-1:0];
        end
    end

    assign prdata = paddr[2] ? {{(32-YEAR_W){1'b0}}, last_year_reg}
                             : {{(32-YEAR_W){1'b0}}, first_year_reg};

    // ---------------- handshake ----------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_room;     // result register can take a beat this cycle
    logic advance;      // input register moves into the result register
    logic in_accept;

    assign out_room  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_room;
    assign in_stall  = s1_valid_reg && !out_room;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // ---------------- input register ----------------
    // leap flag of the load year is worked out here, off the date update path
    opcode_t s1_op_reg;
    date_t   s1_load_reg;
    logic    s1_leap_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg   <= opcode_t'(opcode);
            s1_load_reg <= '{day: load_day, month: load_month, year: load_year};
            s1_leap_reg <= leap_year(load_year);
        end
    end

    // ---------------- held date ----------------
    date_t   date_reg, date_next;
    logic    leap_reg, leap_next;
    date_t   step_date;
    status_t step_status;
    logic    step_load;

    bcdc_step u_step (
        .op          (s1_op_reg),
        .load_date   (s1_load_reg),
        .load_leap   (s1_leap_reg),
        .cur_date    (date_reg),
        .cur_leap    (leap_reg),
        .first_year  (first_year_reg),
        .last_year   (last_year_reg),
        .next_date   (step_date),
        .next_status (step_status),
        .load_taken  (step_load)
    );

    assign date_next = advance ? step_date : date_reg;

    // leap_reg is registered from date_reg.year, so it lags a year roll; the date is
    // then January 1 or December 31, so February is many beats away. A load
    // takes the flag computed in the input register at once.
    assign leap_next = (advance && step_load) ? s1_leap_reg : leap_year(date_reg.year);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_year_reg <= FIRST_YEAR_RST;
            last_year_reg  <= LAST_YEAR_RST;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            date_reg       <= '{day: DAY_FIRST, month: MONTH_JAN, year: FIRST_YEAR_RST};
            leap_reg       <= 1'b0;
        end
        else
        begin
            first_year_reg <= first_year_next;
            last_year_reg  <= last_year_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            date_reg       <= date_next;
            leap_reg       <= leap_next;
        end
    end

    // ---------------- result register ----------------
    date_t   res_date_reg;
    status_t res_status_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_date_reg   <= step_date;
            res_status_reg <= step_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign cur_day   = res_date_reg.day;
    assign cur_month = res_date_reg.month;
    assign cur_year  = res_date_reg.year;
    assign status    = res_status_reg;

`ifndef NO_ASSERTIONS
    // held date is always a real calendar date
    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (date_reg.month >= MONTH_JAN) && (date_reg.month <= MONTH_DEC)
        && (date_reg.day >= DAY_FIRST)
        && (date_reg.day <= month_len(date_reg.month, leap_reg)))
        else $error("held date out of calendar range");

    // leap flag matches the held year once the year has settled
    a_leap_track: assert property (@(posedge clk) disable iff (!rst_n)
        (date_reg.year == $past(date_reg.year)) |-> (leap_reg == leap_year(date_reg.year)))
        else $error("leap flag does not match held year");

    // a window error is only reported at a year boundary
    a_range_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (res_status_reg == ST_RANGE)) |->
        (((res_date_reg.month == MONTH_DEC) && (res_date_reg.day == DAY_LAST))
         || ((res_date_reg.month == MONTH_JAN) && (res_date_reg.day == DAY_FIRST))))
        else $error("range status away from year boundary");

    // a result beat leaves only when the date logic had an item to retire
    a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(s1_valid_reg))
        else $error("result beat without input beat");
`endif

endmodule

`default_nettype wire

/* design/bcdc_step.sv */
// Next-date logic: applies one opcode to the held date (load check, next day,
// previous day) within the year window. Depends on bcdc_pkg.
`default_nettype none

module bcdc_step
    import bcdc_pkg::*;
(
    input  opcode_t                op,
    input  date_t                  load_date,
    input  logic                   load_leap,
    input  date_t                  cur_date,
    input  logic                   cur_leap,
    input  logic [YEAR_W-1:0]      first_year,
    input  logic [YEAR_W-1:0]      last_year,
    output date_t                  next_date,
    output status_t                next_status,
    output logic                   load_taken
);

    logic             load_ok;
    logic [DAY_W-1:0] cur_len;
    logic [DAY_W-1:0] load_len;
    logic [DAY_W-1:0] prev_len;
    logic [MONTH_W-1:0] prev_month;

    assign load_len   = month_len(load_date.month, load_leap);
    assign cur_len    = month_len(cur_date.month, cur_leap);
    assign prev_month = cur_date.month - MONTH_JAN;
    assign prev_len   = month_len(prev_month, cur_leap);

    assign load_ok = (load_date.year >= first_year) && (load_date.year <= last_year)
                  && (load_date.month >= MONTH_JAN) && (load_date.month <= MONTH_DEC)
                  && (load_date.day >= DAY_FIRST) && (load_date.day <= load_len);

    assign load_taken = (op == OP_LOAD) && load_ok;

    always_comb
    begin
        next_date   = cur_date;
        next_status = ST_OK;
        case (op)
            OP_LOAD:
            begin
                if (load_ok)
                    next_date = load_date;
                else
                    next_status = ST_BAD_LOAD;
            end
            OP_NEXT:
            begin
                if (cur_date.day < cur_len)
                begin
                    next_date.day = cur_date.day + 5'd1;
                end
                else if (cur_date.month < MONTH_DEC)
                begin
                    next_date.month = cur_date.month + 4'd1;
                    next_date.day   = DAY_FIRST;
                end
                else if (cur_date.year < last_year)
                begin
                    next_date.year  = cur_date.year + 14'd1;
                    next_date.month = MONTH_JAN;
                    next_date.day   = DAY_FIRST;
                end
                else
                begin
                    next_status = ST_RANGE;
                end
            end
            OP_PREV:
            begin
                if (cur_date.day > DAY_FIRST)
                begin
                    next_date.day = cur_date.day - 5'd1;
                end
                else if (cur_date.month > MONTH_JAN)
                begin
                    next_date.month = prev_month;
                    next_date.day   = prev_len;
                end
                else if (cur_date.year > first_year)
                begin
                    next_date.year  = cur_date.year - 14'd1;
                    next_date.month = MONTH_DEC;
                    next_date.day   = DAY_LAST;
                end
                else
                begin
                    next_status = ST_RANGE;
                end
            end
            default:
            begin
                next_date   = cur_date;
                next_status = ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for bounded_calendar_date_counter. A scripted opening,
// then random phases over many year windows, checked against inline results or an in-bench predictor.
// Depends on bcdc_pkg and the counter RTL only.

module tb_top;
    import bcdc_pkg::*;

    // opcode 3 is not in opcode_t; the block treats it as a no-op
    localparam logic [1:0]        OP_SPARE        = 2'd3;
    localparam logic [2:0]        ADDR_FIRST_YEAR = 3'd0;
    localparam logic [2:0]        ADDR_LAST_YEAR  = 3'd4;
    localparam logic [YEAR_W-1:0] YEAR_MAX        = 14'd9999;
    // marks a plan entry whose window is drawn at random
    localparam logic [YEAR_W-1:0] RANDOM_WINDOW   = 14'h3FFF;

    localparam int NUM_SCRIPT    = 24;
    localparam int NUM_PLAN      = 12;
    localparam int RANDOM_BEATS  = 864;
    // idle margin after the last result, before touching the year registers
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 500;

    typedef struct packed {
        date_t   date;
        status_t st;
    } day_result_t;

    // one input beat; when typed is set the expected result is given inline
    typedef struct packed {
        logic [1:0]         op;
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        bit                 typed;
        logic [DAY_W-1:0]   ed;
        logic [MONTH_W-1:0] em;
        logic [YEAR_W-1:0]  ey;
        status_t            es;
    } beat_t;

    // window plan: fixed corner windows with two random ones mixed in
    localparam logic [YEAR_W-1:0] PLAN_FIRST [NUM_PLAN] = '{
        14'd2016, 14'd2000, 14'd1900, RANDOM_WINDOW, 14'd0, 14'd9999,
        14'd0, 14'd2100, 14'd8190, RANDOM_WINDOW, 14'd3000, 14'd2019
    };
    localparam logic [YEAR_W-1:0] PLAN_LAST [NUM_PLAN] = '{
        14'd2024, 14'd2000, 14'd1900, RANDOM_WINDOW, 14'd0, 14'd9999,
        14'd9999, 14'd2096, 14'd8193, RANDOM_WINDOW, 14'd3001, 14'd2021
    };

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic [1:0]         opcode     = '0;
    logic [DAY_W-1:0]   load_day   = '0;
    logic [MONTH_W-1:0] load_month = '0;
    logic [YEAR_W-1:0]  load_year  = '0;
    logic               out_stall  = 1'b0;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [2:0]         paddr      = '0;
    logic [31:0]        pwdata     = '0;

    logic               in_stall;
    logic               out_valid;
    logic [DAY_W-1:0]   cur_day;
    logic [MONTH_W-1:0] cur_month;
    logic [YEAR_W-1:0]  cur_year;
    logic [1:0]         status;
    logic [31:0]        prdata;
    logic               pready;

    bounded_calendar_date_counter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .load_day   (load_day),
        .load_month (load_month),
        .load_year  (load_year),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cur_day    (cur_day),
        .cur_month  (cur_month),
        .cur_year   (cur_year),
        .status     (status),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Calendar predictor: its own copy of the held date and the window
    // ------------------------------------------------------------------
    date_t             held;
    logic [YEAR_W-1:0] win_first;
    logic [YEAR_W-1:0] win_last;
    day_result_t       pending_dates[$];

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
        if (m == MONTH_FEB)
            return is_leap(y) ? 29 : 28;
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
            return 30;
        return 31;
    endfunction

    // Applies one beat to the held date; returns the date after it and the status.
    // Steps that stay inside the held year never look at the window.
    function automatic day_result_t step_calendar(input logic [1:0] op,
                                                  input logic [DAY_W-1:0] ld,
                                                  input logic [MONTH_W-1:0] lm,
                                                  input logic [YEAR_W-1:0] ly);
        int unsigned d;
        int unsigned m;
        int unsigned y;
        day_result_t r;
        d    = held.day;
        m    = held.month;
        y    = held.year;
        r.st = ST_OK;
        case (op)
            OP_LOAD:
                if (ly < win_first || ly > win_last || lm < MONTH_JAN || lm > MONTH_DEC ||
                    ld < DAY_FIRST || ld > days_in(lm, ly))
                    r.st = ST_BAD_LOAD;
                else
                begin
                    d = ld;
                    m = lm;
                    y = ly;
                end
            OP_NEXT:
                if (d < days_in(m, y))
                    d++;
                else if (m < MONTH_DEC)
                begin
                    m++;
                    d = DAY_FIRST;
                end
                else if (y < win_last)
                begin
                    y++;
                    m = MONTH_JAN;
                    d = DAY_FIRST;
                end
                else
                    r.st = ST_RANGE;
            OP_PREV:
                if (d > DAY_FIRST)
                    d--;
                else if (m > MONTH_JAN)
                begin
                    m--;
                    d = days_in(m, y);
                end
                else if (y > win_first)
                begin
                    y--;
                    m = MONTH_DEC;
                    d = DAY_LAST;
                end
                else
                    r.st = ST_RANGE;
            default: ;  // spare opcode: date held, status ok
        endcase
        held.day   = d[DAY_W-1:0];
        held.month = m[MONTH_W-1:0];
        held.year  = y[YEAR_W-1:0];
        r.date     = held;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    int beats_in     = 0;
    int results_out  = 0;
    int bad_loads    = 0;
    int range_stops  = 0;
    int mismatches   = 0;
    int window_count = 0;
    int gap_pct      = 0;  // chance of an input gap before a beat, percent
    int stall_pct    = 0;  // chance of starting a result stall burst, percent
    int stall_left   = 0;
    int quiet        = 0;

    // Result side stall: random bursts, none while stall_pct is 0.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic check_field(input string name, input logic [YEAR_W-1:0] want,
                               input logic [YEAR_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Every result beat taken is matched against the oldest pending date.
    always @(posedge clk)
    begin : result_check
        day_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_dates.size() == 0)
            begin
                $display("%0t: result beat %0d/%0d/%0d status %0d with none expected",
                         $time, cur_day, cur_month, cur_year, status);
                mismatches++;
            end
            else
            begin
                want = pending_dates.pop_front();
                check_field("cur_day", want.date.day, cur_day);
                check_field("cur_month", want.date.month, cur_month);
                check_field("cur_year", want.date.year, cur_year);
                check_field("status", want.st, status);
                results_out++;
                if (want.st == ST_BAD_LOAD)
                    bad_loads++;
                else if (want.st == ST_RANGE)
                    range_stops++;
            end
        end
    end

    // Watchdog: too long without any beat or register access ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("tb_top: no beat moved in %0d cycles", QUIET_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; all are entered and left on a rising edge
    // ------------------------------------------------------------------

    // Offers one beat, waits for it to be taken, then records what it should give.
    task automatic push_beat(input beat_t b);
        day_result_t seen;
        day_result_t typed_res;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= b.op;
        load_day   <= b.d;
        load_month <= b.m;
        load_year  <= b.y;
        do @(posedge clk); while (in_stall !== 1'b0);
        seen = step_calendar(b.op, b.d, b.m, b.y);
        if (b.typed)
        begin
            typed_res.date.day   = b.ed;
            typed_res.date.month = b.em;
            typed_res.date.year  = b.ey;
            typed_res.st         = b.es;
            pending_dates.push_back(typed_res);
        end
        else
            pending_dates.push_back(seen);
        beats_in++;
    endtask

    // Drop valid and wait until the pipe is empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup, then access; the register takes the data when pready is high.
    // The bus is left selected; the caller releases it after the last write.
    task automatic reg_write(input logic [2:0] addr, input logic [YEAR_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {{(32-YEAR_W){1'b0}}, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (addr == ADDR_FIRST_YEAR)
            win_first = val;
        else
            win_last = val;
    endtask

    task automatic set_window(input logic [YEAR_W-1:0] f, input logic [YEAR_W-1:0] l);
        if ($urandom_range(0, 1))
        begin
            reg_write(ADDR_FIRST_YEAR, f);
            reg_write(ADDR_LAST_YEAR, l);
        end
        else
        begin
            reg_write(ADDR_LAST_YEAR, l);
            reg_write(ADDR_FIRST_YEAR, f);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        window_count++;
    endtask

    // A step beat; the load fields are ignored by the block but still toggled.
    function automatic beat_t step_beat(input logic [1:0] op);
        beat_t b;
        b    = '0;
        b.op = op;
        b.d  = DAY_W'($urandom_range(0, 31));
        b.m  = MONTH_W'($urandom_range(0, 15));
        b.y  = YEAR_W'($urandom_range(0, YEAR_MAX));
        return b;
    endfunction

    // A load aimed at the window, leaning on its ends and on month ends.
    function automatic beat_t good_load();
        beat_t       b;
        int unsigned span;
        int unsigned mlen;
        b    = '0;
        b.op = OP_LOAD;
        span = (win_first <= win_last) ? win_last - win_first : 0;
        case ($urandom_range(0, 3))
            0:       b.y = win_first;
            1:       b.y = win_last;
            default: b.y = YEAR_W'(win_first + $urandom_range(0, span));
        endcase
        case ($urandom_range(0, 4))
            0:       b.m = MONTH_JAN;
            1:       b.m = MONTH_DEC;
            2:       b.m = MONTH_FEB;
            default: b.m = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
        endcase
        mlen = days_in(b.m, b.y);
        case ($urandom_range(0, 4))
            0:       b.d = DAY_FIRST;
            1:       b.d = DAY_W'(mlen);
            2:       b.d = (b.m == MONTH_FEB) ? 5'd29 : DAY_W'(mlen - 1);  // leap-day probe
            default: b.d = DAY_W'($urandom_range(1, mlen));
        endcase
        return b;
    endfunction

    // Odd beats: garbage loads, loads one year outside the window, spare opcodes, stray steps.
    function automatic beat_t noise_beat();
        beat_t b;
        b = step_beat(OP_LOAD);
        case ($urandom_range(0, 4))
            0: b.op = OP_SPARE;
            1: b.op = $urandom_range(0, 1) ? OP_NEXT : OP_PREV;
            2:
            begin
                b.d = DAY_FIRST;
                b.m = MONTH_JAN;
                b.y = (win_last < YEAR_MAX) ? win_last + 1'b1 : win_last;
            end
            3:
            begin
                b.d = DAY_LAST;
                b.m = MONTH_DEC;
                b.y = (win_first > 0) ? win_first - 1'b1 : win_first;
            end
            default: ;
        endcase
        return b;
    endfunction

    // Mostly a good load followed by a walk in one direction with occasional steps back,
    // sometimes long enough to cross months and years; the rest is noise.
    task automatic run_sequence();
        logic [1:0] dir;
        logic [1:0] back;
        int         len;
        if ($urandom_range(0, 4) != 0)
        begin
            push_beat(good_load());
            dir  = $urandom_range(0, 1) ? OP_NEXT : OP_PREV;
            back = (dir == OP_NEXT) ? OP_PREV : OP_NEXT;
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            repeat (len)
                push_beat(step_beat(($urandom_range(0, 6) == 0) ? back : dir));
        end
        else
            push_beat(noise_beat());
    endtask

    // ------------------------------------------------------------------
    // Main flow
    // ------------------------------------------------------------------
    beat_t date_script [NUM_SCRIPT];

    initial
    begin : main_flow
        int unsigned f;
        int unsigned l;
        int          phase_end;

        // Opening script at the reset window 2019..2021. Rows with typed set
        // carry their result inline; the others go through the predictor.
        date_script = '{
            // previous day from the reset date hits the lower end
            '{OP_PREV,  5'd0,  4'd0,  14'd0,    1'b1, 5'd1,  4'd1,  14'd2019, ST_RANGE},
            '{OP_NEXT,  5'd31, 4'd15, 14'd9999, 1'b1, 5'd2,  4'd1,  14'd2019, ST_OK},
            '{OP_LOAD,  5'd31, 4'd12, 14'd2021, 1'b1, 5'd31, 4'd12, 14'd2021, ST_OK},
            // next day from the upper end
            '{OP_NEXT,  5'd0,  4'd0,  14'd0,    1'b1, 5'd31, 4'd12, 14'd2021, ST_RANGE},
            // rejected loads: day 0, April 31, month 0, 13 and 15, year 0,
            // February 29 in a common year, years just outside the window
            '{OP_LOAD,  5'd0,  4'd5,  14'd2020, 1'b1, 5'd31, 4'd12, 14'd2021, ST_BAD_LOAD},
            '{OP_LOAD,  5'd31, 4'd4,  14'd2020, 1'b1, 5'd31, 4'd12, 14'd2021, ST_BAD_LOAD},
            '{OP_LOAD,  5'd1,  4'd0,  14'd2020, 1'b1, 5'd31, 4'd12, 14'd2021, ST_BAD_LOAD},
            '{OP_LOAD,  5'd1,  4'd13, 14'd2020, 1'b1, 5'd31, 4'd12, 14'd2021, ST_BAD_LOAD},
            '{OP_LOAD,  5'd31, 4'd15, 14'd9999, 1'b1, 5'd31, 4'd12, 14'd2021, ST_BAD_LOAD},
            '{OP_LOAD,  5'd1,  4'd1,  14'd0,    1'b1, 5'd31, 4'd12, 14'd2021, ST_BAD_LOAD},
            '{OP_LOAD,  5'd29, 4'd2,  14'd2019, 1'b1, 5'd31, 4'd12, 14'd2021, ST_BAD_LOAD},
            '{OP_LOAD,  5'd1,  4'd1,  14'd2022, 1'b1, 5'd31, 4'd12, 14'd2021, ST_BAD_LOAD},
            '{OP_LOAD,  5'd31, 4'd12, 14'd2018, 1'b1, 5'd31, 4'd12, 14'd2021, ST_BAD_LOAD},
            // leap day and its neighbors
            '{OP_LOAD,  5'd29, 4'd2,  14'd2020, 1'b1, 5'd29, 4'd2,  14'd2020, ST_OK},
            '{OP_NEXT,  5'd0,  4'd0,  14'd0,    1'b1, 5'd1,  4'd3,  14'd2020, ST_OK},
            '{OP_PREV,  5'd0,  4'd0,  14'd0,    1'b0, 5'd0,  4'd0,  14'd0,    ST_OK},
            '{OP_LOAD,  5'd28, 4'd2,  14'd2021, 1'b1, 5'd28, 4'd2,  14'd2021, ST_OK},
            '{OP_NEXT,  5'd0,  4'd0,  14'd0,    1'b0, 5'd0,  4'd0,  14'd0,    ST_OK},
            // year rollover both ways inside the window
            '{OP_LOAD,  5'd31, 4'd12, 14'd2020, 1'b1, 5'd31, 4'd12, 14'd2020, ST_OK},
            '{OP_NEXT,  5'd0,  4'd0,  14'd0,    1'b1, 5'd1,  4'd1,  14'd2021, ST_OK},
            '{OP_PREV,  5'd0,  4'd0,  14'd0,    1'b0, 5'd0,  4'd0,  14'd0,    ST_OK},
            // spare opcode holds the date even with load fields set
            '{OP_SPARE, 5'd31, 4'd12, 14'd2021, 1'b1, 5'd31, 4'd12, 14'd2020, ST_OK},
            '{OP_LOAD,  5'd1,  4'd1,  14'd2019, 1'b1, 5'd1,  4'd1,  14'd2019, ST_OK},
            '{OP_PREV,  5'd31, 4'd15, 14'd9999, 1'b1, 5'd1,  4'd1,  14'd2019, ST_RANGE}
        };

        held.day   = DAY_FIRST;
        held.month = MONTH_JAN;
        held.year  = FIRST_YEAR_RST;
        win_first  = FIRST_YEAR_RST;
        win_last   = LAST_YEAR_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 20;
        stall_pct = 20;
        for (int i = 0; i < NUM_SCRIPT; i++)
            push_beat(date_script[i]);

        // Random phases, one year window each. The registers only change with
        // the pipe empty. The first few steps of a phase run on the date left
        // by the last one, which may now sit outside the new window.
        for (int p = 0; p < NUM_PLAN; p++)
        begin
            settle();
            if (PLAN_FIRST[p] == RANDOM_WINDOW)
            begin
                f = $urandom_range(0, YEAR_MAX);
                l = f + $urandom_range(0, 3);
                if (l > YEAR_MAX)
                    l = YEAR_MAX;
            end
            else
            begin
                f = PLAN_FIRST[p];
                l = PLAN_LAST[p];
            end
            set_window(f[YEAR_W-1:0], l[YEAR_W-1:0]);

            // idling per phase: none, light or heavy; none at all in the last phase
            if (p == NUM_PLAN - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end

            phase_end = beats_in + RANDOM_BEATS / NUM_PLAN;
            repeat ($urandom_range(3, 8))
                push_beat(step_beat($urandom_range(0, 1) ? OP_NEXT : OP_PREV));
            while (beats_in < phase_end)
                run_sequence();
        end

        settle();

        $display("tb_top: %0d beats in, %0d results checked (%0d rejected loads, %0d window stops)",
                 beats_in, results_out, bad_loads, range_stops);
        $display("tb_top: %0d year windows, among them empty, single-year and 0..9999",
                 window_count);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
design/bcdc_pkg.sv
design/bcdc_step.sv
design/bounded_calendar_date_counter.sv
test/tb_top.sv
